@@ rtl/core/rtkns_pkg.sv @@
// ----------------------------------------------------------------------------
// rtkns_pkg
// Shared widths, codes and state encoding for the range top-K nearest search.
// ----------------------------------------------------------------------------
package rtkns_pkg;

	localparam int COMP_W  = 16;   // query / data component
	localparam int ID_W    = 16;   // reported point number
	localparam int DIST_W  = 39;   // squared distance, saturating
	localparam int MAG_W   = 16;   // |component difference|
	localparam int SQ_W    = 32;   // squared difference
	localparam int KREG_W  = 5;
	localparam int BND_W   = 16;
	localparam int DREG_W  = 8;
	localparam int CIDX_W  = 2;
	localparam int CDATA_W = 16;
	localparam int IN_DW   = 16;   // s_tdata width
	localparam int OUT_DW  = 56;   // m_tdata width

	typedef enum logic [1:0] {
		CMD_QUERY  = 2'd0,
		CMD_DATA   = 2'd1,
		CMD_FINISH = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		REG_K_COUNT = 2'd0,
		REG_LOWER   = 2'd1,
		REG_UPPER   = 2'd2,
		REG_DIMS    = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_RUN,    // taking components
		ST_DRAIN,  // waiting for the MAC to finish a point
		ST_OFFER,  // insert, drop (K of 0, none held) or start worst-entry scan
		ST_SCAN,   // walk the held list
		ST_REPL,   // replace worst entry if closer
		ST_PASS,   // start one report pass
		ST_EMIT    // hand a result word to the output register
	} state_t;

endpackage

@@ rtl/core/range_topk_nearest_search.sv @@
// ----------------------------------------------------------------------------
// range_topk_nearest_search
// Range-limited brute-force K-nearest search over streamed vectors.
// ----------------------------------------------------------------------------
// Usage:
//  s_* words: s_tuser is the command (query component, data component,
//  finish), s_tdata the signed component. The query is loaded first, then
//  data points follow, dims components each; points are numbered from 0.
//  cfg_* writes k_count, lower_bound, upper_bound and dims; only while idle.
//  m_* words: one per held point in ascending (distance, id) order, tlast on
//  the final one; an empty search returns one word with tuser set.
//  Throughput: one component per cycle while s_tready is high, through the
//  query store read port and a three-stage subtract/square/accumulate pipe.
//  The closing component of a point is followed by a drain of the pipe,
//  then an insert while fewer than K are held, or else a worst-entry scan
//  of the best list memory, whose single read port also sets the report
//  time: each held point costs one read pass over the held list plus an emit.
//  Reset empties the held list and counters; query store and best list come
//  up undefined. A stalled receiver holds the output register and the report
//  pauses; inputs are not taken until the report is done.
// ----------------------------------------------------------------------------
module range_topk_nearest_search #(
	parameter int MAX_DIMS = 128,
	parameter int MAX_K    = 16,
	parameter int ID_BITS  = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [rtkns_pkg::IN_DW-1:0]       s_tdata,   // [15:0] component
	input  logic [1:0]                        s_tuser,   // [1:0] cmd
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [rtkns_pkg::OUT_DW-1:0]      m_tdata,   // [15:0] point_id, [54:16] distance_sq
	output logic                              m_tuser,   // [0] empty_res
	output logic                              m_tlast,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rtkns_pkg::CIDX_W-1:0]      cfg_index,
	input  logic [rtkns_pkg::CDATA_W-1:0]     cfg_data
);

	localparam int DIM_BITS = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int DW  = ($clog2(MAX_DIMS + 1) > 8) ? $clog2(MAX_DIMS + 1) : 8;
	localparam int KW  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
	localparam int HW  = $clog2(MAX_K + 1);
	localparam int KCW = (HW > rtkns_pkg::KREG_W) ? HW : rtkns_pkg::KREG_W;
	localparam int BW  = (ID_BITS > rtkns_pkg::BND_W) ? ID_BITS : rtkns_pkg::BND_W;
	localparam int DS  = rtkns_pkg::DIST_W;

	typedef struct packed {
		logic [DS-1:0]      dsq;
		logic [ID_BITS-1:0] id;
	} entry_t;

	function automatic logic pair_lt(entry_t a, entry_t b);
		pair_lt = (a.dsq < b.dsq) || ((a.dsq == b.dsq) && (a.id < b.id));
	endfunction

	// configuration
	logic [rtkns_pkg::KREG_W-1:0] k_q;
	logic [rtkns_pkg::BND_W-1:0]  lo_q, hi_q;
	logic [rtkns_pkg::DREG_W-1:0] dims_q;

	// memories
	logic signed [rtkns_pkg::COMP_W-1:0] qmem [MAX_DIMS];
	entry_t                              bmem [MAX_K];

	// streaming side
	rtkns_pkg::state_t state_q, state_d;
	logic [DIM_BITS-1:0] cnt_q;
	logic [ID_BITS:0]    pc_q;
	logic [DS-1:0]       acc_q, dist_q;
	logic [ID_BITS-1:0]  id_q;
	logic                sel_q;

	logic                                vld_s1, vld_s2, vld_s3;
	logic                                end_s1, end_s2, end_s3;
	logic signed [rtkns_pkg::COMP_W-1:0] comp_s1, qd_s1;
	logic [rtkns_pkg::MAG_W-1:0]         mag_s2;
	logic [rtkns_pkg::SQ_W-1:0]          sq_s3;

	// list walk
	logic [HW-1:0] held_q, scan_q, rdi_q, done_q;
	logic          rdv_q, rpt_q, sel_ok_q, have_prev_q;
	entry_t        brd_q, sel_e_q, prev_q;
	logic [KW-1:0] sel_i_q;

	// output register
	logic                     out_vld_q, out_empty_q, out_last_q;
	logic [rtkns_pkg::ID_W-1:0] out_id_q;
	logic [DS-1:0]            out_dist_q;

	// combinational
	logic               in_acc, is_q, is_d, is_f, comp_step, wrap, vec_end, in_range;
	logic [DW-1:0]      dims_x, effd, cnt_next;
	logic [KCW-1:0]     k_x, effk;
	logic [DS:0]        acc_sum;
	logic [DS-1:0]      acc_sat;
	logic signed [rtkns_pkg::COMP_W:0] diff_s1;
	logic [BW-1:0]      pc_x;
	logic               bwe, bre, take, scan_end, out_load, out_free, emit_last;
	logic [KW-1:0]      bwa, bra;
	entry_t             bwd;

	assign cfg_ready = 1'b1;

	assign dims_x = DW'(dims_q);
	assign effd   = (dims_x == '0) ? DW'(1) :
	                (dims_x > DW'(MAX_DIMS)) ? DW'(MAX_DIMS) : dims_x;
	assign k_x    = KCW'(k_q);
	assign effk   = (k_x > KCW'(MAX_K)) ? KCW'(MAX_K) : k_x;

	assign in_acc    = s_tvalid && s_tready;
	assign is_q      = in_acc && (s_tuser == rtkns_pkg::CMD_QUERY);
	assign is_d      = in_acc && (s_tuser == rtkns_pkg::CMD_DATA);
	assign is_f      = in_acc && (s_tuser == rtkns_pkg::CMD_FINISH);
	assign comp_step = is_q || is_d;
	assign cnt_next  = DW'(cnt_q) + DW'(1);
	assign wrap      = (cnt_next >= effd);
	assign vec_end   = is_d && wrap;

	assign pc_x     = BW'(pc_q[ID_BITS-1:0]);
	assign in_range = !pc_q[ID_BITS] && (pc_x >= BW'(lo_q)) && (pc_x <= BW'(hi_q));

	assign diff_s1 = {comp_s1[rtkns_pkg::COMP_W-1], comp_s1} - {qd_s1[rtkns_pkg::COMP_W-1], qd_s1};
	assign acc_sum = {1'b0, acc_q} + (DS + 1)'(sq_s3);
	assign acc_sat = acc_sum[DS] ? {DS{1'b1}} : acc_sum[DS-1:0];

	assign out_free  = !out_vld_q || m_tready;
	assign emit_last = (done_q + HW'(1) == held_q);

	// next state and memory controls
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		bwe      = 1'b0;
		bwa      = held_q[KW-1:0];
		bwd      = '{dsq: dist_q, id: id_q};
		bre      = 1'b0;
		bra      = scan_q[KW-1:0];
		take     = 1'b0;
		scan_end = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			rtkns_pkg::ST_RUN: begin
				s_tready = 1'b1;
				if (vec_end)
					state_d = rtkns_pkg::ST_DRAIN;
				else if (is_f)
					state_d = (held_q == '0) ? rtkns_pkg::ST_EMIT : rtkns_pkg::ST_PASS;
			end
			rtkns_pkg::ST_DRAIN: begin
				if (vld_s3 && end_s3)
					state_d = sel_q ? rtkns_pkg::ST_OFFER : rtkns_pkg::ST_RUN;
			end
			rtkns_pkg::ST_OFFER: begin
				if (KCW'(held_q) < effk) begin
					bwe     = 1'b1;
					state_d = rtkns_pkg::ST_RUN;
				end else if (held_q == '0) begin
					state_d = rtkns_pkg::ST_RUN;
				end else begin
					state_d = rtkns_pkg::ST_SCAN;
				end
			end
			rtkns_pkg::ST_PASS: begin
				state_d = rtkns_pkg::ST_SCAN;
			end
			rtkns_pkg::ST_SCAN: begin
				bre = (scan_q < held_q);
				if (rdv_q) begin
					if (rpt_q)
						take = (!have_prev_q || pair_lt(prev_q, brd_q)) &&
						       (!sel_ok_q || pair_lt(brd_q, sel_e_q));
					else
						take = !sel_ok_q || pair_lt(sel_e_q, brd_q);
					scan_end = (rdi_q == held_q - HW'(1));
				end
				if (scan_end)
					state_d = rpt_q ? rtkns_pkg::ST_EMIT : rtkns_pkg::ST_REPL;
			end
			rtkns_pkg::ST_REPL: begin
				bwa     = sel_i_q;
				bwe     = (dist_q < sel_e_q.dsq);
				state_d = rtkns_pkg::ST_RUN;
			end
			rtkns_pkg::ST_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					if (held_q == '0 || emit_last)
						state_d = rtkns_pkg::ST_RUN;
					else
						state_d = rtkns_pkg::ST_PASS;
				end
			end
			default: state_d = rtkns_pkg::ST_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= rtkns_pkg::ST_RUN;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= rtkns_pkg::KREG_W'(10);
			lo_q   <= '0;
			hi_q   <= '1;
			dims_q <= rtkns_pkg::DREG_W'(128);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rtkns_pkg::REG_K_COUNT: k_q    <= cfg_data[rtkns_pkg::KREG_W-1:0];
				rtkns_pkg::REG_LOWER:   lo_q   <= cfg_data;
				rtkns_pkg::REG_UPPER:   hi_q   <= cfg_data;
				rtkns_pkg::REG_DIMS:    dims_q <= cfg_data[rtkns_pkg::DREG_W-1:0];
				default: ;
			endcase
		end
	end

	// query store: write on query words, registered read feeding the subtract
	always_ff @(posedge clk) begin
		if (is_q)
			qmem[cnt_q] <= s_tdata;
		if (is_d)
			qd_s1 <= qmem[cnt_q];
	end

	// counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			pc_q  <= '0;
		end else if (is_f) begin
			cnt_q <= '0;
			pc_q  <= '0;
		end else begin
			if (comp_step)
				cnt_q <= wrap ? '0 : cnt_q + DIM_BITS'(1);
			if (vec_end && !pc_q[ID_BITS])
				pc_q <= pc_q + (ID_BITS + 1)'(1);
		end
	end

	// MAC pipe; finish drops a partial point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			acc_q  <= '0;
		end else begin
			vld_s1 <= is_d;
			vld_s2 <= vld_s1 && !is_f;
			vld_s3 <= vld_s2 && !is_f;
			if (is_f)
				acc_q <= '0;
			else if (vld_s3)
				acc_q <= end_s3 ? '0 : acc_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (is_d) begin
			comp_s1 <= s_tdata;
			end_s1  <= wrap;
		end
		if (vec_end) begin
			sel_q <= in_range;
			id_q  <= pc_q[ID_BITS-1:0];
		end
		mag_s2 <= diff_s1[rtkns_pkg::COMP_W] ? rtkns_pkg::MAG_W'(-diff_s1)
		                                     : rtkns_pkg::MAG_W'(diff_s1);
		end_s2 <= end_s1;
		sq_s3  <= mag_s2 * mag_s2;
		end_s3 <= end_s2;
		if (vld_s3 && end_s3)
			dist_q <= acc_sat;
	end

	// best list memory
	always_ff @(posedge clk) begin
		if (bwe)
			bmem[bwa] <= bwd;
		if (bre)
			brd_q <= bmem[bra];
	end

	// list walk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			scan_q      <= '0;
			rdv_q       <= 1'b0;
			rpt_q       <= 1'b0;
			sel_ok_q    <= 1'b0;
			have_prev_q <= 1'b0;
			done_q      <= '0;
		end else begin
			if (is_f) begin
				have_prev_q <= 1'b0;
				done_q      <= '0;
			end
			if (state_q == rtkns_pkg::ST_OFFER && bwe)
				held_q <= held_q + HW'(1);
			if ((state_q == rtkns_pkg::ST_OFFER && state_d == rtkns_pkg::ST_SCAN) ||
			    state_q == rtkns_pkg::ST_PASS) begin
				scan_q   <= '0;
				rdv_q    <= 1'b0;
				sel_ok_q <= 1'b0;
				rpt_q    <= (state_q == rtkns_pkg::ST_PASS);
			end
			if (state_q == rtkns_pkg::ST_SCAN) begin
				rdv_q <= bre;
				if (bre)
					scan_q <= scan_q + HW'(1);
				if (take)
					sel_ok_q <= 1'b1;
			end
			if (out_load && held_q != '0) begin
				have_prev_q <= 1'b1;
				done_q      <= done_q + HW'(1);
				if (emit_last)
					held_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rtkns_pkg::ST_SCAN)
			rdi_q <= scan_q;
		if (take) begin
			sel_e_q <= brd_q;
			sel_i_q <= rdi_q[KW-1:0];
		end
		if (out_load)
			prev_q <= sel_e_q;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (out_load)
			out_vld_q <= 1'b1;
		else if (m_tready)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (held_q == '0) begin
				out_id_q    <= '0;
				out_dist_q  <= '0;
				out_empty_q <= 1'b1;
				out_last_q  <= 1'b1;
			end else begin
				out_id_q    <= rtkns_pkg::ID_W'(sel_e_q.id);
				out_dist_q  <= sel_e_q.dsq;
				out_empty_q <= 1'b0;
				out_last_q  <= emit_last;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {1'b0, out_dist_q, out_id_q};
	assign m_tuser  = out_empty_q;
	assign m_tlast  = out_last_q;

	// checks
	a_held_max: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= HW'(MAX_K))
		else $error("held count above MAX_K");

	a_end_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s3 && end_s3) |-> (state_q == rtkns_pkg::ST_DRAIN))
		else $error("point end reached MAC tail outside drain");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tlast)
		else $error("empty marker without tlast");

	a_repl_sel: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rtkns_pkg::ST_REPL) |-> sel_ok_q)
		else $error("replace with no worst entry found");

	a_emit_sel: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && held_q != '0) |-> sel_ok_q)
		else $error("report word with no candidate");

endmodule

@@ tb/tb_range_topk_nearest_search.sv @@
// ----------------------------------------------------------------------------
// tb_range_topk_nearest_search
// Self-checking bench for the range-limited top-K nearest search. A driver
// streams query and point words from a queue, a monitor checks every result
// word against an in-bench predictor of the held list. Directed phases cover
// the component extremes, ties, strict replacement and register extremes;
// random sessions follow with varied idling.
// ----------------------------------------------------------------------------
module tb_range_topk_nearest_search;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QDEPTH     = 128;
	localparam int KMAX       = 16;
	localparam longint unsigned ID_CEIL  = 64'd1 << 16;
	localparam longint unsigned DIST_TOP = (64'd1 << 39) - 64'd1;
	localparam int SETTLE     = 40;
	localparam int QUIET_MAX  = 4000;
	localparam int RAND_WORDS = 220;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]  cmd;
		logic [15:0] comp;
		bit          hold_after;
	} search_word_t;

	typedef struct packed {
		logic [rtkns_pkg::ID_W-1:0]   point_id;
		logic [rtkns_pkg::DIST_W-1:0] dist_sq;
		logic                         empty;
		logic                         is_last;
	} nn_result_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              s_tvalid = 1'b0;
	logic                              s_tready;
	logic [rtkns_pkg::IN_DW-1:0]       s_tdata = '0;
	logic [1:0]                        s_tuser = '0;
	logic                              m_tvalid;
	logic                              m_tready = 1'b0;
	logic [rtkns_pkg::OUT_DW-1:0]      m_tdata;
	logic                              m_tuser;
	logic                              m_tlast;
	logic                              cfg_valid = 1'b0;
	logic                              cfg_ready;
	logic [rtkns_pkg::CIDX_W-1:0]      cfg_index = '0;
	logic [rtkns_pkg::CDATA_W-1:0]     cfg_data = '0;

	range_topk_nearest_search u_top (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor state and register copy
	logic signed [15:0] query_mem [QDEPTH];
	int unsigned        comp_pos;
	longint unsigned    point_num;
	longint unsigned    dist_acc;
	longint unsigned    best_d [KMAX];
	logic [15:0]        best_id [KMAX];
	int unsigned        held;
	logic [4:0]         k_reg = 5'd10;
	logic [15:0]        lo_reg = 16'd0;
	logic [15:0]        hi_reg = 16'd65535;
	logic [7:0]         dims_reg = 8'd128;

	nn_result_t   nearest_due [$];
	search_word_t pending [$];
	search_word_t cur;
	bit           q_written [QDEPTH];
	int unsigned  gen_pos;
	bit           holding;
	int           send_idle_pct;
	int           recv_stall_pct;
	int           n_errors;
	int           words_taken;
	int           words_queued;
	int           results_seen;
	int           reports_seen;
	int           quiet_cycles;

	function automatic int dims_eff();
		if (dims_reg == 8'd0)
			return 1;
		if (dims_reg > QDEPTH)
			return QDEPTH;
		return dims_reg;
	endfunction

	function automatic int k_eff();
		return (k_reg > KMAX) ? KMAX : k_reg;
	endfunction

	function automatic bit pair_less(longint unsigned da, logic [15:0] ia,
			longint unsigned db, logic [15:0] ib);
		return da < db || (da == db && ia < ib);
	endfunction

	function automatic void offer_point(longint unsigned d, logic [15:0] id);
		int unsigned worst;
		if (held < k_eff()) begin
			best_d[held]  = d;
			best_id[held] = id;
			held++;
			return;
		end
		if (held == 0)
			return;
		worst = 0;
		for (int unsigned i = 1; i < held; i++)
			if (pair_less(best_d[worst], best_id[worst], best_d[i], best_id[i]))
				worst = i;
		// equal distance never displaces a held entry
		if (d < best_d[worst]) begin
			best_d[worst]  = d;
			best_id[worst] = id;
		end
	endfunction

	function automatic void search_step(logic [1:0] cmd, logic signed [15:0] comp);
		longint          diff;
		longint unsigned sq;
		int unsigned     order [KMAX];
		int unsigned     m;
		int unsigned     tmp;
		nn_result_t      r;
		case (cmd) inside
			rtkns_pkg::CMD_QUERY, rtkns_pkg::CMD_DATA: begin
				if (cmd == rtkns_pkg::CMD_QUERY) begin
					query_mem[comp_pos % QDEPTH] = comp;
				end else begin
					diff = longint'(comp) - longint'(query_mem[comp_pos % QDEPTH]);
					if (diff < 0)
						diff = -diff;
					sq = diff * diff;
					dist_acc = (dist_acc + sq > DIST_TOP) ? DIST_TOP : dist_acc + sq;
				end
				comp_pos++;
				if (comp_pos >= dims_eff()) begin
					comp_pos = 0;
					// only a data word closes a point
					if (cmd == rtkns_pkg::CMD_DATA) begin
						if (point_num < ID_CEIL && point_num >= lo_reg && point_num <= hi_reg)
							offer_point(dist_acc, point_num[15:0]);
						dist_acc = 0;
						if (point_num < ID_CEIL)
							point_num++;
					end
				end
			end
			rtkns_pkg::CMD_FINISH: begin
				if (held == 0) begin
					r = '0;
					r.empty   = 1'b1;
					r.is_last = 1'b1;
					nearest_due.push_back(r);
				end else begin
					for (int unsigned i = 0; i < held; i++)
						order[i] = i;
					for (int unsigned i = 0; i < held; i++) begin
						m = i;
						for (int unsigned j = i + 1; j < held; j++)
							if (pair_less(best_d[order[j]], best_id[order[j]],
									best_d[order[m]], best_id[order[m]]))
								m = j;
						tmp = order[i];
						order[i] = order[m];
						order[m] = tmp;
					end
					for (int unsigned i = 0; i < held; i++) begin
						r.point_id = best_id[order[i]];
						r.dist_sq  = best_d[order[i]][rtkns_pkg::DIST_W-1:0];
						r.empty    = 1'b0;
						r.is_last  = (i + 1 == held);
						nearest_due.push_back(r);
					end
				end
				held      = 0;
				point_num = 0;
				comp_pos  = 0;
				dist_acc  = 0;
			end
			default: ;
		endcase
	endfunction

	task automatic log_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("MISMATCH @%0t %s: got %0d, want %0d", $realtime, what, got, want);
		n_errors++;
	endtask

	// driver: one word per handshake, pauses after a marked finish
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				search_step(cur.cmd, cur.comp);
				words_taken++;
				if (cur.hold_after)
					holding = 1'b1;
			end
			if (holding && nearest_due.size() == 0)
				holding = 1'b0;
			if (!s_tvalid || s_tready) begin
				if (!holding && pending.size() != 0 &&
						$urandom_range(99) >= send_idle_pct) begin
					cur = pending.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= cur.comp;
					s_tuser  <= cur.cmd;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		nn_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (m_tlast)
					reports_seen++;
				if (nearest_due.size() == 0) begin
					log_mismatch("result word with none pending, point_id",
						m_tdata[rtkns_pkg::ID_W-1:0], 0);
				end else begin
					want = nearest_due.pop_front();
					if (m_tdata[rtkns_pkg::ID_W-1:0] !== want.point_id)
						log_mismatch("point_id", m_tdata[rtkns_pkg::ID_W-1:0],
							want.point_id);
					if (m_tdata[rtkns_pkg::ID_W +: rtkns_pkg::DIST_W] !== want.dist_sq)
						log_mismatch("distance_sq",
							m_tdata[rtkns_pkg::ID_W +: rtkns_pkg::DIST_W], want.dist_sq);
					if (m_tuser !== want.empty)
						log_mismatch("empty_res", m_tuser, want.empty);
					if (m_tlast !== want.is_last)
						log_mismatch("last", m_tlast, want.is_last);
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog on cycles with no handshake anywhere
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == QUIET_MAX) begin
			$display("Timeout: no word moved for %0d cycles", QUIET_MAX);
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic write_reg(rtkns_pkg::reg_idx_t idx, logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			rtkns_pkg::REG_K_COUNT: k_reg    = val[4:0];
			rtkns_pkg::REG_LOWER:   lo_reg   = val;
			rtkns_pkg::REG_UPPER:   hi_reg   = val;
			rtkns_pkg::REG_DIMS:    dims_reg = val[7:0];
			default: ;
		endcase
	endtask

	// generator side: tracks the shared component counter so that a data
	// word never reads a query entry that was never loaded
	function automatic void queue_word(logic [1:0] cmd, logic [15:0] comp, bit hold = 1'b0);
		search_word_t w;
		if (cmd == rtkns_pkg::CMD_DATA && !q_written[gen_pos])
			cmd = rtkns_pkg::CMD_QUERY;
		if (cmd == rtkns_pkg::CMD_QUERY)
			q_written[gen_pos] = 1'b1;
		if (cmd == rtkns_pkg::CMD_QUERY || cmd == rtkns_pkg::CMD_DATA) begin
			gen_pos++;
			if (gen_pos >= dims_eff())
				gen_pos = 0;
		end else if (cmd == rtkns_pkg::CMD_FINISH) begin
			gen_pos = 0;
		end
		if (cmd != CMD_UNUSED)
			words_queued++;
		w.cmd        = cmd;
		w.comp       = comp;
		w.hold_after = hold;
		pending.push_back(w);
	endfunction

	function automatic logic [15:0] rand_comp();
		logic [15:0] v;
		case ($urandom_range(7))
			0: v = 16'h8000;
			1: v = 16'h7FFF;
			2, 3: begin
				v = $urandom_range(8);
				v = v - 16'd4;
			end
			default: v = $urandom_range(16'hFFFF);
		endcase
		return v;
	endfunction

	function automatic void set_idling(int mode);
		case (mode)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
			default: begin send_idle_pct = 34; recv_stall_pct = 34; end
		endcase
	endfunction

	task automatic wait_quiet();
		do @(negedge clk);
		while (pending.size() != 0 || s_tvalid || holding || nearest_due.size() != 0);
		// a closing point may still be in the worst-entry scan
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic queue_point(logic [15:0] a, logic [15:0] b);
		queue_word(rtkns_pkg::CMD_DATA, a);
		queue_word(rtkns_pkg::CMD_DATA, b);
	endtask

	initial begin
		int phase_no;
		int rand_base;
		int npts;
		int lo;
		logic [15:0] hi;
		int ending;
		logic [1:0] c;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: 2-dim vectors, K of 3
		set_idling(0);
		write_reg(rtkns_pkg::REG_K_COUNT, 16'd3);
		write_reg(rtkns_pkg::REG_LOWER, 16'd0);
		write_reg(rtkns_pkg::REG_UPPER, 16'd65535);
		write_reg(rtkns_pkg::REG_DIMS, 16'd2);
		@(negedge clk);
		queue_word(rtkns_pkg::CMD_FINISH, 16'h0000, 1'b1);  // empty report, then pause
		queue_word(rtkns_pkg::CMD_QUERY, 16'h8000);
		queue_word(rtkns_pkg::CMD_QUERY, 16'h7FFF);
		queue_point(16'h7FFF, 16'h8000);         // largest distance
		queue_point(16'h8000, 16'h7FFF);         // zero
		queue_point(16'h8001, 16'h7FFF);         // 1
		queue_point(16'h8001, 16'h7FFE);         // 2, displaces the largest
		queue_point(16'h8000, 16'h7FFE);         // 1, tie broken on id
		queue_point(16'h8001, 16'h7FFF);         // 1, equal: no displacement
		queue_word(CMD_UNUSED, 16'hFFFF);        // unused command
		queue_word(rtkns_pkg::CMD_DATA, 16'h8000);   // data then query close a vector
		queue_word(rtkns_pkg::CMD_QUERY, 16'h0000);
		queue_point(16'h8000, 16'h0000);
		queue_word(rtkns_pkg::CMD_DATA, 16'h0005);   // partial point dropped by finish
		queue_word(rtkns_pkg::CMD_FINISH, 16'hFFFF);
		wait_quiet();

		// K lowered to zero with entries held: replace only, never add
		set_idling(3);
		write_reg(rtkns_pkg::REG_K_COUNT, 16'd2);
		write_reg(rtkns_pkg::REG_DIMS, 16'd1);
		@(negedge clk);
		queue_word(rtkns_pkg::CMD_DATA, 16'd100);
		queue_word(rtkns_pkg::CMD_DATA, 16'hFF9C);
		queue_word(rtkns_pkg::CMD_DATA, 16'd0);
		wait_quiet();
		write_reg(rtkns_pkg::REG_K_COUNT, 16'd0);
		@(negedge clk);
		queue_word(rtkns_pkg::CMD_DATA, 16'h8000);
		queue_word(rtkns_pkg::CMD_DATA, 16'h8001);
		queue_word(rtkns_pkg::CMD_DATA, 16'h1234);
		queue_word(rtkns_pkg::CMD_FINISH, 16'h0000);
		wait_quiet();

		// dims 0 acts as 1, K above the maximum acts as the maximum
		set_idling(2);
		write_reg(rtkns_pkg::REG_K_COUNT, 16'd31);
		write_reg(rtkns_pkg::REG_DIMS, 16'd0);
		@(negedge clk);
		for (int i = 0; i < 20; i++)
			queue_word(rtkns_pkg::CMD_DATA, rand_comp());
		queue_word(rtkns_pkg::CMD_FINISH, 16'h0000);
		wait_quiet();

		// inverted bounds select nothing
		set_idling(1);
		write_reg(rtkns_pkg::REG_LOWER, 16'd5);
		write_reg(rtkns_pkg::REG_UPPER, 16'd3);
		@(negedge clk);
		for (int i = 0; i < 8; i++)
			queue_word(rtkns_pkg::CMD_DATA, rand_comp());
		queue_word(rtkns_pkg::CMD_FINISH, 16'h0000);
		wait_quiet();

		// random sessions
		rand_base = words_queued;
		phase_no = 0;
		while (words_queued - rand_base < RAND_WORDS) begin
			set_idling(phase_no % 4);
			if (phase_no % 2 == 0) begin
				case ($urandom_range(5))
					0: write_reg(rtkns_pkg::REG_K_COUNT, 16'd0);
					1: write_reg(rtkns_pkg::REG_K_COUNT, 16'd1);
					2: write_reg(rtkns_pkg::REG_K_COUNT, 16'd16);
					3: write_reg(rtkns_pkg::REG_K_COUNT, 16'd31);
					default: write_reg(rtkns_pkg::REG_K_COUNT, 16'($urandom_range(2, 15)));
				endcase
				lo = $urandom_range(3);
				case ($urandom_range(5))
					0: hi = 16'd65535;
					1: hi = (lo == 0) ? 16'd0 : 16'(lo - 1);
					default: hi = 16'(lo + $urandom_range(6));
				endcase
				write_reg(rtkns_pkg::REG_LOWER, 16'(lo));
				write_reg(rtkns_pkg::REG_UPPER, hi);
				write_reg(rtkns_pkg::REG_DIMS, 16'($urandom_range(1, 6)));
			end
			@(negedge clk);
			if (phase_no % 2 == 0 || $urandom_range(1) == 1)
				for (int i = 0; i < dims_eff(); i++)
					queue_word(rtkns_pkg::CMD_QUERY, rand_comp());
			npts = $urandom_range(8);
			for (int p = 0; p < npts; p++)
				for (int i = 0; i < dims_eff(); i++) begin
					c = ($urandom_range(11) == 0) ? 2'($urandom_range(3))
					                              : rtkns_pkg::CMD_DATA;
					queue_word(c, rand_comp());
				end
			ending = $urandom_range(9);
			if (ending == 7)
				queue_word(rtkns_pkg::CMD_DATA, rand_comp());
			if (ending <= 7) begin
				queue_word(rtkns_pkg::CMD_FINISH, rand_comp(), phase_no % 3 == 1);
			end else begin
				// leave entries held into the next session, on a vector boundary
				while (gen_pos != 0)
					queue_word(rtkns_pkg::CMD_DATA, rand_comp());
			end
			wait_quiet();
			phase_no++;
		end

		if (nearest_due.size() != 0)
			log_mismatch("results never delivered", nearest_due.size(), 0);
		$display("Ran %0d input words over %0d random sessions plus directed phases",
			words_taken, phase_no);
		$display("Checked %0d result words in %0d reports, %0d mismatches",
			results_seen, reports_seen, n_errors);
		if (n_errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
